### rtl/core/heq_pkg.sv
`timescale 1ns / 1ps
package heq_pkg;

  // Sizes
  localparam int BIN_COUNT  = 4096;
  localparam int BIN_BITS   = 12;
  localparam int COUNT_BITS = 24;
  localparam int LEVEL_BITS = 12;
  localparam int SUM_BITS   = COUNT_BITS + BIN_BITS;
  localparam int PROD_BITS  = SUM_BITS + LEVEL_BITS;
  localparam int NUM_BITS   = PROD_BITS + 1;
  localparam int DEN_BITS   = COUNT_BITS + 1;
  localparam int QUOT_BITS  = LEVEL_BITS + 1;
  localparam int STEP_BITS  = 4;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [BIN_BITS-1:0]   LAST_BIN  = BIN_BITS'(BIN_COUNT - 1);
  localparam logic [LEVEL_BITS-1:0] MAX_RESET = LEVEL_BITS'(255);

  // Request codes
  localparam logic [1:0] ACT_COUNT  = 2'd0;
  localparam logic [1:0] ACT_BUILD  = 2'd1;
  localparam logic [1:0] ACT_MAP    = 2'd2;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_MAP_RD,
    ST_SRCH_RD,
    ST_SRCH_CHK,
    ST_WALK_RD,
    ST_WALK_CHK,
    ST_MUL,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_DONE
  } state_t;

  // How the table is filled during the walk
  typedef enum logic [1:0] {
    FILL_ZERO,
    FILL_FLAT,
    FILL_CUM
  } fill_mode_t;

endpackage

### rtl/core/heq_ram.sv
`timescale 1ns / 1ps
module heq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### rtl/core/heq_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle, quotient saturates at all ones.
module heq_div
  import heq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic [NUM_BITS-1:0]  num,
  input  logic [DEN_BITS-1:0]  den,
  output logic                 done,
  output logic [QUOT_BITS-1:0] quot
);

  logic [NUM_BITS-1:0]  rem_r, rem_nxt;
  logic [NUM_BITS-1:0]  dsh_r, dsh_nxt;
  logic [QUOT_BITS-1:0] quot_r, quot_nxt;
  logic [STEP_BITS-1:0] cnt_r, cnt_nxt;
  logic                 run_r, run_nxt;
  logic                 done_r, done_nxt;
  logic [NUM_BITS-1:0]  den_top;
  logic                 fits;

  // Divisor aligned above the widest quotient
  assign den_top = NUM_BITS'({den, {QUOT_BITS{1'b0}}});
  assign fits    = (rem_r >= dsh_r);

  always_comb begin
    rem_nxt  = rem_r;
    dsh_nxt  = dsh_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    if (start) begin
      if (num >= den_top) begin
        quot_nxt = '1;
        done_nxt = 1'b1;
        run_nxt  = 1'b0;
      end else begin
        rem_nxt  = num;
        dsh_nxt  = NUM_BITS'({den, {(QUOT_BITS-1){1'b0}}});
        quot_nxt = '0;
        cnt_nxt  = STEP_BITS'(QUOT_BITS - 1);
        run_nxt  = 1'b1;
      end
    end else if (run_r) begin
      if (fits) begin
        rem_nxt = rem_r - dsh_r;
      end
      quot_nxt = {quot_r[QUOT_BITS-2:0], fits};
      dsh_nxt  = dsh_r >> 1;
      cnt_nxt  = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    dsh_r  <= dsh_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

### rtl/core/histogram_equalizer.sv
`timescale 1ns / 1ps
// Channel   | Ports                                            | Handshake
// ----------+--------------------------------------------------+-------------------
// request   | in_action, in_sample_value, in_first_channel     | start & !busy
// result    | out_mapped_value, out_build_done                 | out_valid, 1 cycle
// config    | cfg_max_value                                    | cfg_valid & cfg_ready
//
// Count reads the bin, then writes it back with a saturating increment. Map reads the
// table; its result shows on the cycle after, while the next request can be taken.
// Build scans bins 0..first non-empty (stopping at max_value), then walks all 4096 bins;
// for each bin above the first up to max_value in cumulative mode it also runs a multiply
// and then the 13-step divider, clearing the histogram as it goes.
// After reset a clearing pass runs over all 4096 entries of both memories with busy high.
// The receiver cannot stall; configuration is always taken.
module histogram_equalizer
  import heq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  output logic                  busy,
  input  logic [1:0]            in_action,
  input  logic [15:0]           in_sample_value,
  input  logic                  in_first_channel,
  output logic                  out_valid,
  output logic [LEVEL_BITS-1:0] out_mapped_value,
  output logic                  out_build_done,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [LEVEL_BITS-1:0] cfg_max_value
);

  state_t                state_r, state_nxt;
  fill_mode_t            mode_r, mode_nxt;
  logic [BIN_BITS-1:0]   w_r, w_nxt;
  logic [BIN_BITS-1:0]   idx_r, idx_nxt;
  logic [BIN_BITS-1:0]   first_r, first_nxt;
  logic [COUNT_BITS-1:0] fc_r, fc_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt;
  logic [SUM_BITS-1:0]   sum_r, sum_nxt;
  logic [PROD_BITS-1:0]  prod_r;
  logic [LEVEL_BITS-1:0] max_r;
  logic                  out_valid_r, out_valid_nxt;
  logic [LEVEL_BITS-1:0] out_mapped_r, out_mapped_nxt;
  logic                  out_done_r, out_done_nxt;

  logic                  bin_we, tab_we;
  logic [BIN_BITS-1:0]   bin_waddr, bin_raddr, tab_waddr, tab_raddr;
  logic [COUNT_BITS-1:0] bin_wdata, bin_rdata;
  logic [LEVEL_BITS-1:0] tab_wdata, tab_rdata;

  logic                  div_start, div_done;
  logic [QUOT_BITS-1:0]  div_quot;
  logic [COUNT_BITS-1:0] span;
  logic [NUM_BITS-1:0]   div_num;
  logic [DEN_BITS-1:0]   div_den;
  logic [LEVEL_BITS-1:0] level;
  logic [BIN_BITS-1:0]   in_idx;
  logic                  in_cum;

  // Sample clamped to the top level
  assign in_idx = (in_sample_value > 16'(max_r)) ? max_r : in_sample_value[BIN_BITS-1:0];

  assign span    = total_r - fc_r;
  assign div_num = {prod_r, 1'b0} + NUM_BITS'(span);
  assign div_den = {span, 1'b0};
  assign level   = (div_quot > QUOT_BITS'(max_r)) ? max_r : div_quot[LEVEL_BITS-1:0];
  assign in_cum  = (mode_r == FILL_CUM) && (w_r > first_r) && (w_r <= max_r);

  // Next state and datapath
  always_comb begin
    state_nxt      = state_r;
    mode_nxt       = mode_r;
    w_nxt          = w_r;
    idx_nxt        = idx_r;
    first_nxt      = first_r;
    fc_nxt         = fc_r;
    total_nxt      = total_r;
    sum_nxt        = sum_r;
    out_valid_nxt  = 1'b0;
    out_mapped_nxt = '0;
    out_done_nxt   = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        w_nxt = w_r + 1'b1;
        if (w_r == LAST_BIN) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          idx_nxt = in_idx;
          w_nxt   = '0;
          if (in_action == ACT_COUNT && in_first_channel) begin
            state_nxt = ST_CNT_WR;
          end else if (in_action == ACT_MAP) begin
            state_nxt = ST_MAP_RD;
          end else if (in_action == ACT_BUILD) begin
            state_nxt = ST_SRCH_RD;
          end
        end
      end
      ST_CNT_WR: begin
        if (total_r != COUNT_MAX) begin
          total_nxt = total_r + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_MAP_RD: begin
        out_valid_nxt  = 1'b1;
        out_mapped_nxt = tab_rdata;
        state_nxt      = ST_IDLE;
      end
      ST_SRCH_RD: begin
        state_nxt = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        if (bin_rdata != '0) begin
          first_nxt = w_r;
          fc_nxt    = bin_rdata;
          sum_nxt   = '0;
          w_nxt     = '0;
          state_nxt = ST_WALK_RD;
          if (total_r == '0) begin
            mode_nxt = FILL_ZERO;
          end else if (bin_rdata >= total_r) begin
            mode_nxt = FILL_FLAT;
          end else begin
            mode_nxt = FILL_CUM;
          end
        end else if (w_r == max_r) begin
          mode_nxt  = FILL_ZERO;
          w_nxt     = '0;
          state_nxt = ST_WALK_RD;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_WALK_RD: begin
        state_nxt = ST_WALK_CHK;
      end
      ST_WALK_CHK: begin
        if (in_cum) begin
          sum_nxt   = sum_r + SUM_BITS'(bin_rdata);
          state_nxt = ST_MUL;
        end else if (w_r == LAST_BIN) begin
          state_nxt = ST_DONE;
        end else begin
          w_nxt     = w_r + 1'b1;
          state_nxt = ST_WALK_RD;
        end
      end
      ST_MUL: begin
        state_nxt = ST_DIV_GO;
      end
      ST_DIV_GO: begin
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) begin
          if (w_r == LAST_BIN) begin
            state_nxt = ST_DONE;
          end else begin
            w_nxt     = w_r + 1'b1;
            state_nxt = ST_WALK_RD;
          end
        end
      end
      ST_DONE: begin
        total_nxt     = '0;
        out_valid_nxt = 1'b1;
        out_done_nxt  = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Memory and unit controls
  always_comb begin
    bin_we    = 1'b0;
    bin_waddr = w_r;
    bin_wdata = '0;
    bin_raddr = w_r;
    tab_we    = 1'b0;
    tab_waddr = w_r;
    tab_wdata = '0;
    tab_raddr = in_idx;
    div_start = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        bin_we = 1'b1;
        tab_we = 1'b1;
      end
      ST_IDLE: begin
        bin_raddr = in_idx;
      end
      ST_CNT_WR: begin
        bin_we    = 1'b1;
        bin_waddr = idx_r;
        bin_wdata = (bin_rdata == COUNT_MAX) ? bin_rdata : bin_rdata + 1'b1;
      end
      ST_WALK_CHK: begin
        bin_we = 1'b1;
        if (!in_cum) begin
          tab_we    = 1'b1;
          tab_wdata = (mode_r == FILL_FLAT) ? first_r : '0;
        end
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
      end
      ST_DIV_WAIT: begin
        tab_we    = div_done;
        tab_wdata = level;
      end
      default: begin
        bin_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      w_r         <= '0;
      total_r     <= '0;
      max_r       <= MAX_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      w_r         <= w_nxt;
      total_r     <= total_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        max_r <= cfg_max_value;
      end
    end
    mode_r       <= mode_nxt;
    idx_r        <= idx_nxt;
    first_r      <= first_nxt;
    fc_r         <= fc_nxt;
    sum_r        <= sum_nxt;
    prod_r       <= PROD_BITS'(sum_r * max_r);
    out_mapped_r <= out_mapped_nxt;
    out_done_r   <= out_done_nxt;
  end

  heq_ram #(.WIDTH(COUNT_BITS), .DEPTH(BIN_COUNT)) u_bins (
    .clk   (clk),
    .we    (bin_we),
    .waddr (bin_waddr),
    .wdata (bin_wdata),
    .raddr (bin_raddr),
    .rdata (bin_rdata)
  );

  heq_ram #(.WIDTH(LEVEL_BITS), .DEPTH(BIN_COUNT)) u_table (
    .clk   (clk),
    .we    (tab_we),
    .waddr (tab_waddr),
    .wdata (tab_wdata),
    .raddr (tab_raddr),
    .rdata (tab_rdata)
  );

  heq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign busy             = (state_r != ST_IDLE);
  assign cfg_ready        = 1'b1;
  assign out_valid        = out_valid_r;
  assign out_mapped_value = out_mapped_r;
  assign out_build_done   = out_done_r;

endmodule
